### design/grc_pkg.sv
`timescale 1ns / 1ps
package grc_pkg;

  localparam int unsigned MAP_DIM_DEF   = 64;
  localparam int unsigned MAX_STEPS_DEF = 128;

  localparam int unsigned COORD_W   = 10;  // signed cell coordinate, covers -1..256
  localparam int unsigned ANGLE_W   = 12;
  localparam int unsigned POS_W     = 14;
  localparam int unsigned DIM_W     = 7;
  localparam int unsigned CELL_W    = 6;
  localparam int unsigned MAG_W     = 15;  // magnitude of a Q1.14 sine or cosine
  localparam int unsigned MA_W      = 23;
  localparam int unsigned MB_W      = 15;
  localparam int unsigned PROD_W    = MA_W + MB_W;
  localparam int unsigned DX_W      = 23;  // 2^22 / 1 is the largest delta
  localparam int unsigned SD_W      = 32;
  localparam int unsigned DIV_NUM_W = 32;
  localparam int unsigned DIV_DEN_W = 15;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [MB_W-1:0] SIN_A = 15'd25736;
  localparam logic [MB_W-1:0] SIN_B = 15'd10512;
  localparam logic [MB_W-1:0] SIN_C = 15'd1160;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd3;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_ZLOAD, ST_M0, ST_M1, ST_M2, ST_M3, ST_WFIN,
    ST_DIVX, ST_DIVXW, ST_DIVY, ST_DIVYW, ST_MULX, ST_MULY, ST_SYI,
    ST_CHECK, ST_TEST, ST_LDIV, ST_LDIVW, ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    MUL_ZZ, MUL_Z2C, MUL_Z2I, MUL_ZM, MUL_FX, MUL_FY
  } mul_op_e;

  typedef enum logic [1:0] {
    DIV_DX, DIV_DY, DIV_LEN
  } div_op_e;

  typedef struct packed {
    logic    clr_en;
    logic    in_ready;
    logic    cell_wr;
    logic    cast_start;
    logic    zload;
    logic    wave;
    logic    mul_en;
    mul_op_e mul_op;
    logic    wave_fin;
    logic    div_start;
    logic    div_cap;
    div_op_e div_op;
    logic    sx_init;
    logic    sy_init;
    logic    escape;
    logic    hit;
    logic    step;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_valid;
    logic in_cast;
    logic oob;
    logic wall;
    logic steps_zero;
    logic steps_max;
    logic div_done;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

### design/grid_ray_cast_dda.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser: action; tdata: cell and angle
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: hit cell, side, length, escape
// cfg       in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// After reset the map store is swept clear, one cell per cycle, over all
// MAP_DIM*MAP_DIM cells (4096 by default); no request is accepted meanwhile.
// A write request is stored as soon as it is accepted. A cast first computes
// sine and cosine on one shared multiplier, then runs two reciprocal
// divisions; it then reads each cell walked through from the map memory, and
// ends with a length division when a wall is hit beyond the first cell.
// Only one request is in flight; a finished result waits in the output
// register, and a new request is taken as soon as that result is loaded.
module grid_ray_cast_dda #(
  parameter int unsigned MAP_DIM   = grc_pkg::MAP_DIM_DEF,
  parameter int unsigned MAX_STEPS = grc_pkg::MAX_STEPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [5:0] cell_col, [11:6] cell_row, [12] cell_is_wall, [24:13] ray_angle
  input  logic [grc_pkg::DATA_W-1:0]     s_axis_tdata,
  // [0] action
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [5:0] hit_col, [11:6] hit_row, [12] hit_side, [28:13] ray_length, [29] escaped
  output logic [grc_pkg::DATA_W-1:0]     m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [grc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [grc_pkg::POS_W-1:0]      cfg_data_i
);
  import grc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Registers are always writable; the user must change them only while no cast runs, which the block does not enforce.
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = cmd.in_ready;

  grc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  grc_datapath #(
    .MAP_DIM   (MAP_DIM),
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (s_axis_tvalid),
    .in_user_i   (s_axis_tuser[0]),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // The divider is only restarted once it has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.div_start |-> !sts.div_busy)
    else $error("divider restarted while busy");

  // An escaped result carries no cell, side or length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && m_axis_tdata[29] |-> m_axis_tdata[28:0] == '0)
    else $error("escaped result with nonzero fields");

  // No request is taken while the clearing pass still owns the write port.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.clr_en |-> !s_axis_tready)
    else $error("request accepted during map clear");

  // A result is loaded only when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending result overwritten");
endmodule

### design/grc_ram.sv
`timescale 1ns / 1ps
module grc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### design/grc_div.sv
`timescale 1ns / 1ps
module grc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [grc_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [grc_pkg::DIV_DEN_W-1:0]  den_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [grc_pkg::DIV_NUM_W-1:0]  quot_o
);
  import grc_pkg::*;
  localparam int unsigned CNT_W = $clog2(DIV_NUM_W);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_DEN_W:0]   rem_q, rem_d, rem_sh;
  logic [DIV_NUM_W-1:0] q_q, q_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic                 ge;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    q_d    = q_q;
    den_d  = den_q;
    rem_sh = {rem_q[DIV_DEN_W-1:0], q_q[DIV_NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      q_d    = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sh - {1'b0, den_q} : rem_sh;
      q_d   = {q_q[DIV_NUM_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = q_q;
endmodule

### design/grc_datapath.sv
`timescale 1ns / 1ps
module grc_datapath #(
  parameter int unsigned MAP_DIM   = grc_pkg::MAP_DIM_DEF,
  parameter int unsigned MAX_STEPS = grc_pkg::MAX_STEPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  grc_pkg::cmd_t                  cmd_i,
  output grc_pkg::sts_t                  sts_o,
  input  logic                           in_valid_i,
  input  logic                           in_user_i,
  input  logic [grc_pkg::DATA_W-1:0]     in_data_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [grc_pkg::DATA_W-1:0]     out_data_o,
  input  logic                           cfg_valid_i,
  input  logic [grc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [grc_pkg::POS_W-1:0]      cfg_data_i
);
  import grc_pkg::*;
  localparam int unsigned DEPTH = MAP_DIM * MAP_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = $clog2(MAX_STEPS + 1);
  localparam int unsigned LIN_W = 20;

  // Input fields.
  logic [CELL_W-1:0]  in_col, in_row;
  logic               in_wall;
  logic [ANGLE_W-1:0] in_angle;
  assign in_col   = in_data_i[5:0];
  assign in_row   = in_data_i[11:6];
  assign in_wall  = in_data_i[12];
  assign in_angle = in_data_i[24:13];

  // Configuration registers.
  logic [POS_W-1:0] px_q, py_q;
  logic [DIM_W-1:0] mw_q, mh_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= POS_W'(128);
      py_q <= POS_W'(128);
      mw_q <= DIM_W'(64);
      mh_q <= DIM_W'(64);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PLAYER_X:   px_q <= cfg_data_i;
        CFG_PLAYER_Y:   py_q <= cfg_data_i;
        CFG_MAP_WIDTH:  mw_q <= cfg_data_i[DIM_W-1:0];
        CFG_MAP_HEIGHT: mh_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Map store and its clearing pass.
  logic [AW-1:0]    clr_q;
  logic [LIN_W-1:0] wr_lin, rd_lin;
  logic             wr_ok, ram_we, ram_wd, ram_rd;
  logic signed [COORD_W-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_en) clr_q <= clr_q + AW'(1);
  end

  assign wr_lin = LIN_W'(in_row) * LIN_W'(MAP_DIM) + LIN_W'(in_col);
  assign rd_lin = LIN_W'(cy_q[COORD_W-2:0]) * LIN_W'(MAP_DIM) + LIN_W'(cx_q[COORD_W-2:0]);
  assign wr_ok  = (9'(in_col) < 9'(MAP_DIM)) && (9'(in_row) < 9'(MAP_DIM));
  assign ram_we = cmd_i.clr_en || (cmd_i.cell_wr && wr_ok);
  assign ram_wd = cmd_i.clr_en ? 1'b0 : in_wall;

  grc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_i.clr_en ? clr_q : wr_lin[AW-1:0]),
    .wdata_i (ram_wd),
    .raddr_i (rd_lin[AW-1:0]),
    .rdata_o (ram_rd)
  );

  // Sine and cosine by the quarter-wave polynomial on a shared multiplier.
  logic [ANGLE_W-1:0] angle_q, wave_ang;
  logic [10:0]        qq;
  logic [MAG_W-1:0]   z_q, z2_q, prod_hi, s_mag_q, c_mag_q;
  logic               s_neg_q, c_neg_q;
  logic [MA_W-1:0]    mul_a;
  logic [MB_W-1:0]    mul_b;
  logic [PROD_W-1:0]  prod_q;
  logic [8:0]         frac_x, frac_y;
  logic [DX_W-1:0]    dx_q, dy_q;

  assign wave_ang = angle_q + (cmd_i.wave ? ANGLE_W'(1024) : ANGLE_W'(0));
  assign qq       = wave_ang[10] ? 11'd1024 - {1'b0, wave_ang[9:0]} : {1'b0, wave_ang[9:0]};
  assign prod_hi  = prod_q[28:14];
  assign frac_x   = c_neg_q ? {1'b0, px_q[7:0]} : 9'd256 - {1'b0, px_q[7:0]};
  assign frac_y   = s_neg_q ? {1'b0, py_q[7:0]} : 9'd256 - {1'b0, py_q[7:0]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      MUL_ZZ:  begin mul_a = MA_W'(z_q);     mul_b = z_q;               end
      MUL_Z2C: begin mul_a = MA_W'(prod_hi); mul_b = SIN_C;             end
      MUL_Z2I: begin mul_a = MA_W'(z2_q);    mul_b = SIN_B - prod_hi;   end
      MUL_ZM:  begin mul_a = MA_W'(z_q);     mul_b = SIN_A - prod_hi;   end
      MUL_FX:  begin mul_a = dx_q;           mul_b = MB_W'(frac_x);     end
      MUL_FY:  begin mul_a = dy_q;           mul_b = MB_W'(frac_y);     end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cast_start) angle_q <= in_angle;
    if (cmd_i.zload) z_q <= {qq, 4'b0};
    if (cmd_i.mul_en) prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (cmd_i.mul_en && cmd_i.mul_op == MUL_Z2C) z2_q <= prod_hi;
    if (cmd_i.wave_fin) begin
      if (cmd_i.wave) begin
        c_mag_q <= prod_hi;
        c_neg_q <= wave_ang[11] && (prod_hi != '0);
      end else begin
        s_mag_q <= prod_hi;
        s_neg_q <= wave_ang[11] && (prod_hi != '0);
      end
    end
  end

  // Divider operands.
  logic [DIV_NUM_W-1:0]      div_num, quot;
  logic [DIV_DEN_W-1:0]      div_den;
  logic                      side_q, div_busy, div_done;
  logic signed [LIN_W-1:0]   cb, bnd;
  logic [LIN_W-1:0]          abs_b;

  assign cb    = side_q ? LIN_W'(cy_q) + LIN_W'(s_neg_q) : LIN_W'(cx_q) + LIN_W'(c_neg_q);
  assign bnd   = {cb[LIN_W-9:0], 8'h00} - LIN_W'(side_q ? py_q : px_q);
  assign abs_b = bnd[LIN_W-1] ? LIN_W'(-bnd) : LIN_W'(bnd);

  always_comb begin
    div_num = '0;
    div_den = '0;
    case (cmd_i.div_op)
      DIV_DX:  begin div_num = DIV_NUM_W'(1) << 22; div_den = c_mag_q; end
      DIV_DY:  begin div_num = DIV_NUM_W'(1) << 22; div_den = s_mag_q; end
      DIV_LEN: begin
        div_num = {abs_b[17:0], 14'b0};
        div_den = side_q ? s_mag_q : c_mag_q;
      end
      default: ;
    endcase
  end

  grc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Walk state and result.
  logic [SD_W-1:0]    sx_q, sy_q;
  logic [SW-1:0]      steps_q;
  logic               go_x;
  logic [CELL_W-1:0]  res_col_q, res_row_q;
  logic               res_side_q, res_esc_q;
  logic [LEN_W-1:0]   res_len_q;
  logic signed [COORD_W-1:0] w_lim, h_lim;

  assign go_x  = (s_mag_q == '0) || ((c_mag_q != '0) && (sx_q < sy_q));
  assign w_lim = (COORD_W'(mw_q) > COORD_W'(MAP_DIM)) ? COORD_W'(MAP_DIM) : COORD_W'(mw_q);
  assign h_lim = (COORD_W'(mh_q) > COORD_W'(MAP_DIM)) ? COORD_W'(MAP_DIM) : COORD_W'(mh_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cast_start) begin
      cx_q    <= COORD_W'(px_q[13:8]);
      cy_q    <= COORD_W'(py_q[13:8]);
      steps_q <= '0;
      side_q  <= 1'b0;
    end
    if (cmd_i.div_cap) begin
      case (cmd_i.div_op)
        DIV_DX:  dx_q <= (c_mag_q == '0) ? '0 : quot[DX_W-1:0];
        DIV_DY:  dy_q <= (s_mag_q == '0) ? '0 : quot[DX_W-1:0];
        DIV_LEN: res_len_q <= (div_den == '0) ? '0 :
                              (quot[DIV_NUM_W-1:LEN_W] != '0) ? '1 : quot[LEN_W-1:0];
        default: ;
      endcase
    end
    if (cmd_i.sx_init) sx_q <= SD_W'(prod_q[PROD_W-1:8]);
    if (cmd_i.sy_init) sy_q <= SD_W'(prod_q[PROD_W-1:8]);
    if (cmd_i.step) begin
      if (go_x) begin
        sx_q   <= sx_q + SD_W'(dx_q);
        cx_q   <= c_neg_q ? cx_q - COORD_W'(1) : cx_q + COORD_W'(1);
        side_q <= 1'b0;
      end else begin
        sy_q   <= sy_q + SD_W'(dy_q);
        cy_q   <= s_neg_q ? cy_q - COORD_W'(1) : cy_q + COORD_W'(1);
        side_q <= 1'b1;
      end
      steps_q <= steps_q + SW'(1);
    end
    if (cmd_i.escape) begin
      res_col_q  <= '0;
      res_row_q  <= '0;
      res_side_q <= 1'b0;
      res_len_q  <= '0;
      res_esc_q  <= 1'b1;
    end
    if (cmd_i.hit) begin
      res_col_q  <= cx_q[CELL_W-1:0];
      res_row_q  <= cy_q[CELL_W-1:0];
      res_side_q <= side_q;
      res_len_q  <= '0;
      res_esc_q  <= 1'b0;
    end
  end

  // Output register.
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {2'b0, res_esc_q, res_len_q, res_side_q, res_row_q, res_col_q};
    end
  end
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    sts_o.clr_last   = clr_q == AW'(DEPTH - 1);
    sts_o.in_valid   = in_valid_i;
    sts_o.in_cast    = in_user_i == ACT_CAST;
    sts_o.oob        = cx_q[COORD_W-1] || cy_q[COORD_W-1] || (cx_q >= w_lim) || (cy_q >= h_lim);
    sts_o.wall       = ram_rd;
    sts_o.steps_zero = steps_q == '0;
    sts_o.steps_max  = steps_q >= SW'(MAX_STEPS);
    sts_o.div_done   = div_done;
    sts_o.div_busy   = div_busy;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end
endmodule

### design/grc_ctrl.sv
`timescale 1ns / 1ps
module grc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  grc_pkg::sts_t sts_i,
  output grc_pkg::cmd_t cmd_o
);
  import grc_pkg::*;

  state_e state_q, state_d;
  logic   wave_q, wave_d;

  always_comb begin
    state_d = state_q;
    wave_d  = wave_q;
    case (state_q)
      ST_CLEAR: if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (sts_i.in_valid && sts_i.in_cast) begin
          state_d = ST_ZLOAD;
          wave_d  = 1'b0;
        end
      end
      ST_ZLOAD: state_d = ST_M0;
      ST_M0:    state_d = ST_M1;
      ST_M1:    state_d = ST_M2;
      ST_M2:    state_d = ST_M3;
      ST_M3:    state_d = ST_WFIN;
      ST_WFIN: begin
        if (wave_q) begin
          state_d = ST_DIVX;
        end else begin
          state_d = ST_ZLOAD;
          wave_d  = 1'b1;
        end
      end
      ST_DIVX:  state_d = ST_DIVXW;
      ST_DIVXW: if (sts_i.div_done) state_d = ST_DIVY;
      ST_DIVY:  state_d = ST_DIVYW;
      ST_DIVYW: if (sts_i.div_done) state_d = ST_MULX;
      ST_MULX:  state_d = ST_MULY;
      ST_MULY:  state_d = ST_SYI;
      ST_SYI:   state_d = ST_CHECK;
      ST_CHECK: state_d = sts_i.oob ? ST_DONE : ST_TEST;
      ST_TEST: begin
        if (sts_i.wall) state_d = sts_i.steps_zero ? ST_DONE : ST_LDIV;
        else state_d = sts_i.steps_max ? ST_DONE : ST_CHECK;
      end
      ST_LDIV:  state_d = ST_LDIVW;
      ST_LDIVW: if (sts_i.div_done) state_d = ST_DONE;
      ST_DONE:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.wave = wave_q;
    case (state_q)
      ST_CLEAR: cmd_o.clr_en = 1'b1;
      ST_IDLE: begin
        cmd_o.in_ready   = 1'b1;
        cmd_o.cell_wr    = sts_i.in_valid && !sts_i.in_cast;
        cmd_o.cast_start = sts_i.in_valid && sts_i.in_cast;
      end
      ST_ZLOAD: cmd_o.zload = 1'b1;
      ST_M0: begin cmd_o.mul_en = 1'b1; cmd_o.mul_op = MUL_ZZ;  end
      ST_M1: begin cmd_o.mul_en = 1'b1; cmd_o.mul_op = MUL_Z2C; end
      ST_M2: begin cmd_o.mul_en = 1'b1; cmd_o.mul_op = MUL_Z2I; end
      ST_M3: begin cmd_o.mul_en = 1'b1; cmd_o.mul_op = MUL_ZM;  end
      ST_WFIN: cmd_o.wave_fin = 1'b1;
      ST_DIVX: begin cmd_o.div_start = 1'b1; cmd_o.div_op = DIV_DX; end
      ST_DIVXW: begin cmd_o.div_cap = sts_i.div_done; cmd_o.div_op = DIV_DX; end
      ST_DIVY: begin cmd_o.div_start = 1'b1; cmd_o.div_op = DIV_DY; end
      ST_DIVYW: begin cmd_o.div_cap = sts_i.div_done; cmd_o.div_op = DIV_DY; end
      ST_MULX: begin cmd_o.mul_en = 1'b1; cmd_o.mul_op = MUL_FX; end
      ST_MULY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_op  = MUL_FY;
        cmd_o.sx_init = 1'b1;
      end
      ST_SYI: cmd_o.sy_init = 1'b1;
      ST_CHECK: cmd_o.escape = sts_i.oob;
      ST_TEST: begin
        cmd_o.hit    = sts_i.wall;
        cmd_o.escape = !sts_i.wall && sts_i.steps_max;
        cmd_o.step   = !sts_i.wall && !sts_i.steps_max;
      end
      ST_LDIV: begin cmd_o.div_start = 1'b1; cmd_o.div_op = DIV_LEN; end
      ST_LDIVW: begin cmd_o.div_cap = sts_i.div_done; cmd_o.div_op = DIV_LEN; end
      ST_DONE: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      wave_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wave_q  <= wave_d;
    end
  end
endmodule
